// File: rtl/bbpt_pkg.sv
// ----------------------------------------------------------------------------
// Buzzer beep pattern timer package
// Command codes, pattern presets and field layout shared by the block and its
// checker.
// ----------------------------------------------------------------------------
package bbpt_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_TICK   = 3'd0;
  localparam cmd_t CMD_BEEP   = 3'd1;
  localparam cmd_t CMD_DANGER = 3'd2;
  localparam cmd_t CMD_SOS    = 3'd3;
  localparam cmd_t CMD_ENABLE = 3'd4;

  localparam int TIME_W  = 32;
  localparam int DUR_W   = 16;
  localparam int BEEPS_W = 3;   // largest preset count is 6
  localparam int LEN_W   = 7;   // largest preset phase length is 120 ms

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [DUR_W-1:0]   dur_t;
  typedef logic [BEEPS_W-1:0] beeps_t;
  typedef logic [LEN_W-1:0]   len_t;

  localparam beeps_t DANGER_BEEPS = 3'd2;
  localparam len_t   DANGER_ON    = 7'd90;
  localparam len_t   DANGER_OFF   = 7'd90;
  localparam beeps_t SOS_BEEPS    = 3'd6;
  localparam len_t   SOS_ON       = 7'd120;
  localparam len_t   SOS_OFF      = 7'd120;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_PIN_BIT = 0;
  localparam int OUT_EN_BIT  = 1;

  // Unsigned wraparound distance now - deadline, read as signed, is >= 0.
  function automatic logic deadline_reached(time_t now, time_t deadline);
    time_t diff;
    diff = now - deadline;
    return ~diff[TIME_W-1];
  endfunction

endpackage

// File: rtl/buzzer_beep_pattern_timer.sv
// ----------------------------------------------------------------------------
// Buzzer beep pattern timer
// Executes tick, single beep, preset pattern and enable commands and reports
// the buzzer pin level with polarity applied plus the enable flag.
// ----------------------------------------------------------------------------
// Path: a command passes the input register, then the result register,
// before it appears as a result.
// Throughput: one command per clock unless the result stalls; the state update
// is a single pass of 32-bit add and compare logic between the two registers.
// Reset (rst_n low, synchronous): both stages empty, drive idle, buzzer
// enabled, time counter and deadlines zero, polarity active high.
module buzzer_beep_pattern_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2:0]                      in_tuser,   // [2:0] cmd
  input  logic [bbpt_pkg::IN_TDATA_W-1:0] in_tdata,   // [15:0] duration_ms,
                                                      // [16] enable_value,
                                                      // [23:17] zero
  // Result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bbpt_pkg::OUT_TDATA_W-1:0] out_tdata, // [0] pin_level,
                                                      // [1] enabled,
                                                      // [7:2] zero
  // Configuration: polarity register
  input  logic                            cfg_we,
  input  logic                            cfg_wdata   // active_high
);
  import bbpt_pkg::*;

  // Input register stage. It may be loaded while a result still waits at the
  // output, so the upstream side keeps moving during a short stall.
  logic  s1_valid_r;
  cmd_t  s1_cmd_r;
  dur_t  s1_dur_r;
  logic  s1_en_r;

  // Result register stage.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic active_high_r;

  // Timer state.
  time_t  time_now_r,         time_now_nxt;
  logic   enable_flag_r,      enable_flag_nxt;
  logic   sounding_r,         sounding_nxt;
  logic   single_active_r,    single_active_nxt;
  time_t  single_deadline_r,  single_deadline_nxt;
  logic   pattern_active_r,   pattern_active_nxt;
  logic   pattern_phase_on_r, pattern_phase_on_nxt;
  beeps_t beeps_left_r,       beeps_left_nxt;
  len_t   on_length_r,        on_length_nxt;
  len_t   off_length_r,       off_length_nxt;
  time_t  pattern_deadline_r, pattern_deadline_nxt;

  logic   advance;
  logic   in_xfer;
  time_t  time_inc;
  beeps_t beeps_dec;

  // The command in stage one executes when the result register can take it.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign time_inc  = time_now_r + time_t'(1);
  assign beeps_dec = (beeps_left_r != '0) ? beeps_left_r - beeps_t'(1) : '0;

  // Single-pass state update for the command held in stage one.
  always_comb begin
    time_now_nxt         = time_now_r;
    enable_flag_nxt      = enable_flag_r;
    sounding_nxt         = sounding_r;
    single_active_nxt    = single_active_r;
    single_deadline_nxt  = single_deadline_r;
    pattern_active_nxt   = pattern_active_r;
    pattern_phase_on_nxt = pattern_phase_on_r;
    beeps_left_nxt       = beeps_left_r;
    on_length_nxt        = on_length_r;
    off_length_nxt       = off_length_r;
    pattern_deadline_nxt = pattern_deadline_r;

    case (s1_cmd_r)
      CMD_TICK: begin
        time_now_nxt = time_inc;
        // An expiring single beep only silences the drive if no pattern owns it.
        if (single_active_r && deadline_reached(time_inc, single_deadline_r)) begin
          single_active_nxt = 1'b0;
          if (!pattern_active_r) begin
            sounding_nxt = 1'b0;
          end
        end
        if (pattern_active_r && deadline_reached(time_inc, pattern_deadline_r)) begin
          if (pattern_phase_on_r) begin
            sounding_nxt         = 1'b0;
            pattern_phase_on_nxt = 1'b0;
            pattern_deadline_nxt = time_inc + time_t'(off_length_r);
          end else begin
            beeps_left_nxt = beeps_dec;
            if (beeps_dec == '0) begin
              pattern_active_nxt = 1'b0;
              sounding_nxt       = 1'b0;
            end else begin
              sounding_nxt         = 1'b1;
              pattern_phase_on_nxt = 1'b1;
              pattern_deadline_nxt = time_inc + time_t'(on_length_r);
            end
          end
        end
      end
      CMD_BEEP: begin
        if (!enable_flag_r) begin
          sounding_nxt = 1'b0;
        end else begin
          sounding_nxt        = 1'b1;
          single_active_nxt   = 1'b1;
          single_deadline_nxt = time_now_r + time_t'(s1_dur_r);
        end
      end
      CMD_DANGER, CMD_SOS: begin
        if (!enable_flag_r) begin
          sounding_nxt = 1'b0;
        end else begin
          pattern_active_nxt   = 1'b1;
          pattern_phase_on_nxt = 1'b1;
          sounding_nxt         = 1'b1;
          if (s1_cmd_r == CMD_DANGER) begin
            beeps_left_nxt       = DANGER_BEEPS;
            on_length_nxt        = DANGER_ON;
            off_length_nxt       = DANGER_OFF;
            pattern_deadline_nxt = time_now_r + time_t'(DANGER_ON);
          end else begin
            beeps_left_nxt       = SOS_BEEPS;
            on_length_nxt        = SOS_ON;
            off_length_nxt       = SOS_OFF;
            pattern_deadline_nxt = time_now_r + time_t'(SOS_ON);
          end
        end
      end
      CMD_ENABLE: begin
        enable_flag_nxt = s1_en_r;
        // Muting cancels every timer; enabling leaves the drive as it is.
        if (!s1_en_r) begin
          single_active_nxt  = 1'b0;
          pattern_active_nxt = 1'b0;
          sounding_nxt       = 1'b0;
        end
      end
      default: begin
        // Unused codes leave the state alone and still produce a result.
      end
    endcase
  end

  // Result word: pin level is the sounding state with the polarity applied.
  always_comb begin
    out_data_nxt              = '0;
    out_data_nxt[OUT_PIN_BIT] = sounding_nxt ^ ~active_high_r;
    out_data_nxt[OUT_EN_BIT]  = enable_flag_nxt;
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= in_tuser;
      s1_dur_r <= in_tdata[DUR_W-1:0];
      s1_en_r  <= in_tdata[DUR_W];
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Polarity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r <= 1'b1;
    end else if (cfg_we) begin
      active_high_r <= cfg_wdata;
    end
  end

  // Timer state commits when the command leaves stage one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r         <= '0;
      enable_flag_r      <= 1'b1;
      sounding_r         <= 1'b0;
      single_active_r    <= 1'b0;
      single_deadline_r  <= '0;
      pattern_active_r   <= 1'b0;
      pattern_phase_on_r <= 1'b0;
      beeps_left_r       <= '0;
      on_length_r        <= '0;
      off_length_r       <= '0;
      pattern_deadline_r <= '0;
    end else if (advance) begin
      time_now_r         <= time_now_nxt;
      enable_flag_r      <= enable_flag_nxt;
      sounding_r         <= sounding_nxt;
      single_active_r    <= single_active_nxt;
      single_deadline_r  <= single_deadline_nxt;
      pattern_active_r   <= pattern_active_nxt;
      pattern_phase_on_r <= pattern_phase_on_nxt;
      beeps_left_r       <= beeps_left_nxt;
      on_length_r        <= on_length_nxt;
      off_length_r       <= off_length_nxt;
      pattern_deadline_r <= pattern_deadline_nxt;
    end
  end

endmodule

// File: rtl/bbpt_checker.sv
// ----------------------------------------------------------------------------
// Buzzer beep pattern timer checker
// Port-level assertions on the stream handshakes of the timer.
// ----------------------------------------------------------------------------
module bbpt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bbpt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bbpt_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // With the result register empty, the input stage always drains.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready with empty result register");

  // A transfer that finds the result register empty in the next cycle shows up
  // as a result in the cycle after that.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 !out_tvalid |=> out_tvalid)
    else $error("accepted command produced no result");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_EN_BIT+1] == '0)
    else $error("result padding not zero");

endmodule

bind buzzer_beep_pattern_timer bbpt_checker u_bbpt_checker (.*);
